>>> design/dbe_pkg.sv
package dbe_pkg;

	localparam int MAX_SWITCHES_DEF = 8;
	localparam int SW_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		EV_PRESS         = 2'd0,
		EV_RELEASE_SHORT = 2'd1,
		EV_RELEASE_HOLD  = 2'd2,
		EV_HOLD          = 2'd3
	} event_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWITCH_COUNT   = 2'd0,
		REG_DEBOUNCE_TICKS = 2'd1,
		REG_HOLD_TICKS     = 2'd2,
		REG_REPEAT_TICKS   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0] switch_count;
		logic [7:0] debounce_ticks;
		logic [7:0] hold_ticks;
		logic [7:0] repeat_ticks;
	} cfg_t;

	localparam logic [3:0] SWITCH_COUNT_RST   = 4'd8;
	localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd5;
	localparam logic [7:0] HOLD_TICKS_RST     = 8'd100;
	localparam logic [7:0] REPEAT_TICKS_RST   = 8'd150;

endpackage

>>> design/multi_button_debounce_hold_events.sv
// Debounce and hold-event detector for up to eight active-low buttons.
// Input channel: one item per tick (in_valid / in_stall) carrying pin_levels,
// bit i = raw level of switch i, 0 pressed. Output channel (out_valid /
// out_stall): one item per event with switch_index, event_code and
// last_event; events of a tick come in ascending switch order, the final
// one flagged. A tick with no event produces no output item.
// An accepted item waits in the input register until the event register is
// free; then the switch state updates and the item's first event shows on the output.
// The output register sends one event per cycle while out_stall is low, and a
// tick raises at most MAX_SWITCHES events; an input register takes the next
// tick while the current tick's events drain.
// The user is to write configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block itself does not enforce this. Reset: all switches released,
// counters cleared, registers at 8, 5, 100 and 150. While out_stall is high
// the shown event holds, one more tick is buffered, and then in_stall rises.
module multi_button_debounce_hold_events #(
	parameter int MAX_SWITCHES = dbe_pkg::MAX_SWITCHES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            pin_levels,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dbe_pkg::SW_IDX_W-1:0]          switch_index,
	output logic [1:0]                            event_code,
	output logic                                  last_event,
	input  logic                                  cfg_we,
	input  logic [dbe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dbe_pkg::CFG_DATA_W-1:0]        cfg_data
);

	dbe_pkg::cfg_t        cfg_q;
	logic                 valid_s1;
	logic [7:0]           pins_s1;
	logic                 load;
	logic                 ser_free;
	logic [3:0]           count_eff;
	logic [MAX_SWITCHES-1:0] active;
	logic [MAX_SWITCHES-1:0] ev_valid;
	logic [MAX_SWITCHES-1:0] ld_mask;
	dbe_pkg::event_code_t ev_code [MAX_SWITCHES];
	dbe_pkg::event_code_t sel_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_count   <= dbe_pkg::SWITCH_COUNT_RST;
			cfg_q.debounce_ticks <= dbe_pkg::DEBOUNCE_TICKS_RST;
			cfg_q.hold_ticks     <= dbe_pkg::HOLD_TICKS_RST;
			cfg_q.repeat_ticks   <= dbe_pkg::REPEAT_TICKS_RST;
		end else if (cfg_we) begin
			case (dbe_pkg::cfg_reg_t'(cfg_index))
				dbe_pkg::REG_SWITCH_COUNT:   cfg_q.switch_count   <= cfg_data[3:0];
				dbe_pkg::REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data;
				dbe_pkg::REG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data;
				dbe_pkg::REG_REPEAT_TICKS:   cfg_q.repeat_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the buffered tick once the event register has drained
	assign load     = valid_s1 && ser_free;
	assign in_stall = valid_s1 && !ser_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pins_s1 <= pin_levels;
		end
	end

	assign count_eff = (cfg_q.switch_count > 4'(MAX_SWITCHES)) ? 4'(MAX_SWITCHES)
		: cfg_q.switch_count;

	for (genvar i = 0; i < MAX_SWITCHES; i++) begin : g_lane
		assign active[i]  = 4'(i) < count_eff;
		assign ld_mask[i] = ev_valid[i] && active[i];

		dbe_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (load && active[i]),
			.raw      (pins_s1[i]),
			.cfg      (cfg_q),
			.ev_valid (ev_valid[i]),
			.ev_code  (ev_code[i])
		);
	end

	dbe_ser #(
		.NUM_SW (MAX_SWITCHES)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ld_mask   (ld_mask),
		.ld_codes  (ev_code),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sel_idx   (switch_index),
		.sel_code  (sel_code),
		.sel_last  (last_event),
		.free      (ser_free)
	);

	assign event_code = sel_code;

endmodule

>>> design/dbe_lane.sv
module dbe_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   raw,
	input  dbe_pkg::cfg_t          cfg,
	output logic                   ev_valid,
	output dbe_pkg::event_code_t   ev_code
);

	// accepted level doubles as the switch state: both always move together
	logic       level_q;
	logic [7:0] dbc_q;
	logic [7:0] hold_q;

	logic       differs;
	logic       take;
	logic       now;
	logic [7:0] dbc_inc;
	logic [7:0] dbc_next;
	logic [7:0] hold_inc;
	logic [7:0] hold_next;

	always_comb begin
		differs   = raw != level_q;
		dbc_inc   = dbc_q + 8'd1;
		take      = differs && (dbc_inc == cfg.debounce_ticks);
		dbc_next  = (differs && !take) ? dbc_inc : 8'd0;
		now       = take ? raw : level_q;
		hold_inc  = hold_q + 8'd1;
		hold_next = hold_q;
		ev_valid  = 1'b0;
		ev_code   = dbe_pkg::EV_PRESS;
		if (!now && level_q) begin
			hold_next = 8'd0;
			ev_valid  = 1'b1;
			ev_code   = dbe_pkg::EV_PRESS;
		end else if (now && !level_q) begin
			ev_valid = 1'b1;
			ev_code  = (hold_q < cfg.hold_ticks) ? dbe_pkg::EV_RELEASE_SHORT
				: dbe_pkg::EV_RELEASE_HOLD;
		end else if (!now && !level_q && (hold_q < cfg.repeat_ticks)) begin
			hold_next = hold_inc;
			// repeat point wins and folds the count back to the hold point
			if (hold_inc == cfg.repeat_ticks) begin
				ev_valid  = 1'b1;
				ev_code   = dbe_pkg::EV_HOLD;
				hold_next = cfg.hold_ticks;
			end else if (hold_inc == cfg.hold_ticks) begin
				ev_valid = 1'b1;
				ev_code  = dbe_pkg::EV_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			dbc_q   <= 8'd0;
			hold_q  <= 8'd0;
		end else if (en) begin
			level_q <= now;
			dbc_q   <= dbc_next;
			hold_q  <= hold_next;
		end
	end

endmodule

>>> design/dbe_ser.sv
module dbe_ser #(
	parameter int NUM_SW = dbe_pkg::MAX_SWITCHES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [NUM_SW-1:0]                   ld_mask,
	input  dbe_pkg::event_code_t                ld_codes [NUM_SW],
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [dbe_pkg::SW_IDX_W-1:0]        sel_idx,
	output dbe_pkg::event_code_t                sel_code,
	output logic                                sel_last,
	output logic                                free
);

	logic [NUM_SW-1:0]    mask_q;
	dbe_pkg::event_code_t code_q [NUM_SW];
	logic [NUM_SW-1:0]    sel_oh;
	logic                 take;

	// lowest pending switch goes first
	always_comb begin
		sel_idx  = '0;
		sel_code = dbe_pkg::EV_PRESS;
		sel_oh   = '0;
		for (int i = NUM_SW - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel_idx  = dbe_pkg::SW_IDX_W'(i);
				sel_code = code_q[i];
				sel_oh   = NUM_SW'(1) << i;
			end
		end
	end

	assign out_valid = mask_q != '0;
	assign sel_last  = (mask_q & ~sel_oh) == '0;
	assign take      = out_valid && !out_stall;
	assign free      = !out_valid || (take && sel_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= ld_mask;
		end else if (take) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= ld_codes;
		end
	end

endmodule

>>> design/dbe_checker.sv
module dbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] switch_index,
	input logic [1:0] event_code,
	input logic       last_event
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(switch_index)
			&& $stable(event_code) && $stable(last_event))
		else $error("stalled event changed");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_event |=> out_valid)
		else $error("tick ended without last event");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_event |=> switch_index > $past(switch_index))
		else $error("events of a tick not in ascending switch order");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with no event pending");

endmodule

bind multi_button_debounce_hold_events dbe_checker u_dbe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.switch_index (switch_index),
	.event_code   (event_code),
	.last_event   (last_event)
);

>>> verif/tb_multi_button_debounce_hold_events.sv
module tb_multi_button_debounce_hold_events;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SW = dbe_pkg::MAX_SWITCHES_DEF;
	localparam int SETTLE_CYC = 2 * MAX_SW + 4;
	localparam int LIMIT = 500000;

	typedef struct packed {
		logic [dbe_pkg::SW_IDX_W-1:0] idx;
		dbe_pkg::event_code_t         code;
		logic                         last;
	} sw_event_t;

	typedef enum {PAT_BOUNCY, PAT_NOISE, PAT_CONST} stim_kind_t;

	typedef struct {
		bit                 is_cfg;
		dbe_pkg::cfg_reg_t  reg_sel;
		logic [7:0]         value;
		int                 exp_n;
	} dir_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     pin_levels;
	logic                           out_valid;
	logic                           out_stall;
	logic [dbe_pkg::SW_IDX_W-1:0]   switch_index;
	logic [1:0]                     event_code;
	logic                           last_event;
	logic                           cfg_we;
	logic [dbe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dbe_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow of the block's registers and per-switch state
	logic [3:0] sh_switch_count;
	logic [7:0] sh_debounce;
	logic [7:0] sh_hold;
	logic [7:0] sh_repeat;
	logic [MAX_SW-1:0] acc_level;
	logic [MAX_SW-1:0] sw_state;
	logic [7:0] deb_count [MAX_SW];
	logic [7:0] hold_cnt [MAX_SW];

	sw_event_t pending_events[$];
	dir_row_t dir_rows[$];

	// bouncy pattern generator: per-switch target level and run length
	logic [MAX_SW-1:0] sw_target;
	int sw_run [MAX_SW];

	int ticks_in;
	int events_seen;
	int last_tick_events;
	int err_cnt;
	int phase_cnt;
	int cycle_cnt;
	bit tx_idle_on;
	bit rx_idle_on;

	multi_button_debounce_hold_events u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.switch_index (switch_index),
		.event_code   (event_code),
		.last_event   (last_event),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR: %s", msg);
	endtask

	// Advance every scanned switch by one tick; queue the events it raises.
	function automatic int predict_tick(input logic [7:0] pins);
		int cnt;
		int n;
		logic raw;
		logic prev;
		logic now;
		bit has_ev;
		dbe_pkg::event_code_t code;
		sw_event_t evs [MAX_SW];
		cnt = (sh_switch_count > MAX_SW) ? MAX_SW : int'(sh_switch_count);
		n = 0;
		code = dbe_pkg::EV_PRESS;
		for (int i = 0; i < cnt; i++) begin
			raw = pins[i];
			prev = sw_state[i];
			now = prev;
			has_ev = 1'b0;
			if (raw != acc_level[i]) begin
				deb_count[i] = deb_count[i] + 8'd1;
				if (deb_count[i] == sh_debounce) begin
					acc_level[i] = raw;
					now = raw;
					deb_count[i] = 8'd0;
				end
			end else begin
				deb_count[i] = 8'd0;
			end
			if (!now && prev) begin
				hold_cnt[i] = 8'd0;
				code = dbe_pkg::EV_PRESS;
				has_ev = 1'b1;
			end else if (now && !prev) begin
				code = (hold_cnt[i] < sh_hold) ? dbe_pkg::EV_RELEASE_SHORT
					: dbe_pkg::EV_RELEASE_HOLD;
				has_ev = 1'b1;
			end else if (!now && !prev) begin
				if (hold_cnt[i] < sh_repeat) begin
					hold_cnt[i] = hold_cnt[i] + 8'd1;
					if (hold_cnt[i] == sh_hold) begin
						code = dbe_pkg::EV_HOLD;
						has_ev = 1'b1;
					end
					if (hold_cnt[i] == sh_repeat) begin
						code = dbe_pkg::EV_HOLD;
						has_ev = 1'b1;
						hold_cnt[i] = sh_hold;
					end
				end
			end
			sw_state[i] = now;
			if (has_ev) begin
				evs[n].idx = dbe_pkg::SW_IDX_W'(i);
				evs[n].code = code;
				evs[n].last = 1'b0;
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			evs[k].last = (k == n - 1);
			pending_events.push_back(evs[k]);
		end
		return n;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			last_tick_events = predict_tick(pin_levels);
			ticks_in++;
		end
	end

	always @(posedge clk) begin : chk_out
		sw_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				flag_error($sformatf("unexpected event: switch %0d code %0d last %0d",
					switch_index, event_code, last_event));
			end else begin
				want = pending_events.pop_front();
				if (switch_index !== want.idx)
					flag_error($sformatf("switch_index: expected %0d, got %0d",
						want.idx, switch_index));
				if (event_code !== want.code)
					flag_error($sformatf("event_code (switch %0d): expected %0d, got %0d",
						want.idx, want.code, event_code));
				if (last_event !== want.last)
					flag_error($sformatf("last_event (switch %0d): expected %0d, got %0d",
						want.idx, want.last, last_event));
			end
		end
	end

	// receiver: random stall bursts while enabled
	initial begin : rx_side
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 16);
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TIMEOUT after %0d cycles, %0d events still expected",
			cycle_cnt, pending_events.size());
		$display("multi_button_debounce_hold_events test failed");
		$finish;
	end

	task automatic send_tick(input logic [7:0] pins);
		int gap;
		int target;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pin_levels <= pins;
		target = ticks_in + 1;
		do @(negedge clk); while (ticks_in < target);
	endtask

	// Stop sending, wait for every queued event, then let a silent tick finish.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input dbe_pkg::cfg_reg_t sel, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		case (sel)
			dbe_pkg::REG_SWITCH_COUNT:   sh_switch_count = value[3:0];
			dbe_pkg::REG_DEBOUNCE_TICKS: sh_debounce = value;
			dbe_pkg::REG_HOLD_TICKS:     sh_hold = value;
			dbe_pkg::REG_REPEAT_TICKS:   sh_repeat = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] bouncy_pins(input int span);
		logic [7:0] p;
		for (int i = 0; i < MAX_SW; i++) begin
			if (sw_run[i] <= 0) begin
				sw_target[i] = ~sw_target[i];
				sw_run[i] = $urandom_range(1, span);
			end
			sw_run[i]--;
			p[i] = sw_target[i];
			// bounce
			if ($urandom_range(0, 15) == 0)
				p[i] = ~p[i];
		end
		return p;
	endfunction

	task automatic run_phase(input logic [7:0] sc, input logic [7:0] deb,
			input logic [7:0] hold, input logic [7:0] rep, input int n_ticks,
			input stim_kind_t kind, input logic [7:0] fixed_pins);
		int span;
		logic [7:0] pins;
		settle_idle();
		write_reg(dbe_pkg::REG_SWITCH_COUNT, sc);
		write_reg(dbe_pkg::REG_DEBOUNCE_TICKS, deb);
		write_reg(dbe_pkg::REG_HOLD_TICKS, hold);
		write_reg(dbe_pkg::REG_REPEAT_TICKS, rep);
		phase_cnt++;
		span = int'(deb) + int'(rep) + 4;
		for (int t = 0; t < n_ticks; t++) begin
			case (kind)
				PAT_BOUNCY: pins = bouncy_pins(span);
				PAT_NOISE:  pins = 8'($urandom_range(0, 255));
				default:    pins = fixed_pins;
			endcase
			send_tick(pins);
		end
	endtask

	function automatic dir_row_t tick_row(input logic [7:0] pins, input int n);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.reg_sel = dbe_pkg::REG_SWITCH_COUNT;
		r.value = pins;
		r.exp_n = n;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input dbe_pkg::cfg_reg_t sel,
			input logic [7:0] value);
		dir_row_t r;
		r.is_cfg = 1'b1;
		r.reg_sel = sel;
		r.value = value;
		r.exp_n = -1;
		return r;
	endfunction

	initial begin : main
		logic [7:0] h;
		logic [7:0] r;
		in_valid = 1'b0;
		pin_levels = 8'hFF;
		cfg_we = 1'b0;
		cfg_index = dbe_pkg::REG_SWITCH_COUNT;
		cfg_data = '0;
		arst_n = 1'b0;
		ticks_in = 0;
		events_seen = 0;
		last_tick_events = 0;
		err_cnt = 0;
		phase_cnt = 1;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		sh_switch_count = dbe_pkg::SWITCH_COUNT_RST;
		sh_debounce = dbe_pkg::DEBOUNCE_TICKS_RST;
		sh_hold = dbe_pkg::HOLD_TICKS_RST;
		sh_repeat = dbe_pkg::REPEAT_TICKS_RST;
		acc_level = '1;
		sw_state = '1;
		sw_target = '1;
		for (int i = 0; i < MAX_SW; i++) begin
			deb_count[i] = 8'd0;
			hold_cnt[i] = 8'd0;
			sw_run[i] = 0;
		end

		// reset values: all eight switches press after five ticks, release after five
		dir_rows.push_back(tick_row(8'hFF, 0));
		repeat (4) dir_rows.push_back(tick_row(8'h00, 0));
		dir_rows.push_back(tick_row(8'h00, 8));
		repeat (4) dir_rows.push_back(tick_row(8'hFF, 0));
		dir_rows.push_back(tick_row(8'hFF, 8));
		// three switches (upper data bits dropped), fast hold and repeat
		dir_rows.push_back(cfg_row(dbe_pkg::REG_SWITCH_COUNT, 8'h13));
		dir_rows.push_back(cfg_row(dbe_pkg::REG_DEBOUNCE_TICKS, 8'd1));
		dir_rows.push_back(cfg_row(dbe_pkg::REG_HOLD_TICKS, 8'd2));
		dir_rows.push_back(cfg_row(dbe_pkg::REG_REPEAT_TICKS, 8'd4));
		dir_rows.push_back(tick_row(8'h00, 3));
		dir_rows.push_back(tick_row(8'h00, 0));
		dir_rows.push_back(tick_row(8'h00, 3));
		dir_rows.push_back(tick_row(8'h00, 0));
		dir_rows.push_back(tick_row(8'h00, 3));
		dir_rows.push_back(tick_row(8'hFE, -1));
		// zero switches: nothing scanned
		dir_rows.push_back(cfg_row(dbe_pkg::REG_SWITCH_COUNT, 8'd0));
		dir_rows.push_back(tick_row(8'hFF, 0));
		// count above the limit acts as eight
		dir_rows.push_back(cfg_row(dbe_pkg::REG_SWITCH_COUNT, 8'hFF));
		dir_rows.push_back(tick_row(8'hFF, -1));
		// repeat not above hold
		dir_rows.push_back(cfg_row(dbe_pkg::REG_HOLD_TICKS, 8'd3));
		dir_rows.push_back(cfg_row(dbe_pkg::REG_REPEAT_TICKS, 8'd2));
		repeat (4) dir_rows.push_back(tick_row(8'h7F, -1));
		dir_rows.push_back(tick_row(8'hFF, -1));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				settle_idle();
				write_reg(dir_rows[k].reg_sel, dir_rows[k].value);
			end else begin
				send_tick(dir_rows[k].value);
				if (dir_rows[k].exp_n >= 0 && last_tick_events != dir_rows[k].exp_n)
					flag_error($sformatf("row %0d: expected %0d events, predicted %0d",
						k, dir_rows[k].exp_n, last_tick_events));
			end
		end

		// low extremes of the timing registers
		run_phase(8'd8, 8'd1, 8'd1, 8'd2, 30, PAT_BOUNCY, 8'hFF);

		for (int p = 0; p < 4; p++) begin
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			h = 8'($urandom_range(1, 10));
			// one setting has repeat at or below hold
			r = (p == 2) ? 8'($urandom_range(1, h)) : h + 8'($urandom_range(1, 10));
			run_phase(8'(($urandom_range(0, 15) << 4) | $urandom_range(1, 8)),
				8'($urandom_range(1, 4)), h, r, 30, PAT_BOUNCY, 8'hFF);
		end

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_phase(8'hFF, 8'd1, 8'd3, 8'd5, 30, PAT_NOISE, 8'hFF);
		// debounce zero wraps the counter: accepted after 256 ticks
		run_phase(8'h02, 8'd0, 8'd1, 8'd2, 260, PAT_CONST, 8'hFC);

		// final stretch with no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		h = 8'($urandom_range(1, 8));
		run_phase(8'd8, 8'($urandom_range(1, 3)), h, h + 8'($urandom_range(1, 6)),
			40, PAT_BOUNCY, 8'hFF);

		settle_idle();

		$display("Sent %0d ticks over %0d settings, %0d events checked, %0d mismatches.",
			ticks_in, phase_cnt, events_seen, err_cnt);
		$display("Covered debounce wrap, count zero and above eight, short repeat, stalls.");
		if (err_cnt == 0 && pending_events.size() == 0) begin
			$display("multi_button_debounce_hold_events test passed");
		end else begin
			$display("multi_button_debounce_hold_events test failed");
		end
		$finish;
	end

endmodule
